FILE: hdl/edf_pkg.sv
`default_nettype none

package edf_pkg;

    localparam int NUM_TASKS = 4;
    localparam int TIME_BITS = 16;

    // Config packing: four 16-bit slots per 64-bit register
    localparam int CFG_SLOTS  = 4;
    localparam int SLOT_W     = 16;
    localparam int CFG_W      = CFG_SLOTS * SLOT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int ACTIVE_W   = 3;

    localparam int TASK_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int GRANT_W = 2;
    localparam int MISS_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TASKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXEC_BUDGETS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REL_DEADLINES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_PERIODS  = 2'd3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef t_time t_time_arr [NUM_TASKS];

    typedef struct packed {
        logic              found;
        logic [TASK_W-1:0] idx;
    } t_pick;

    // Slot t of a packed config register; tasks without a slot read zero
    function automatic t_time cfg_field(input logic [CFG_W-1:0] cfg, input int t);
        t_time f;
        f = '0;
        for (int k = 0; k < CFG_SLOTS; k++) begin
            if (k == t) begin
                f = TIME_BITS'(cfg[k*SLOT_W +: SLOT_W]);
            end
        end
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/edf_pick.sv
`default_nettype none

module edf_pick import edf_pkg::*; (
    input  wire t_time_arr             i_budget,
    input  wire t_time_arr             i_deadline,
    input  wire logic [NUM_TASKS-1:0]  i_active,
    output t_pick                      o_pick
);

    // Earliest deadline among pending tasks; strict compare keeps the lowest index on ties
    always_comb begin
        t_time best;
        o_pick = '0;
        best   = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            if (i_active[t] && (i_budget[t] != '0)) begin
                if (!o_pick.found || (i_deadline[t] < best)) begin
                    o_pick.found = 1'b1;
                    o_pick.idx   = TASK_W'(t);
                    best         = i_deadline[t];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/edf_tick_scheduler.sv
`default_nettype none
// An accepted item waits in the input register; its result is registered in the output register once that is free.
// Throughput: one item per cycle while the output is not stalled; the pick and task state update are combinational.
// A stalled result holds in the output register while one more item waits in the input register.
// Reset (synchronous, active low) clears all task state to zero and the config registers
// to their reset values (one active task, zero budgets, deadlines and periods).

module edf_tick_scheduler import edf_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [0] restart, [7:1] zero

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [1:0] granted_task, [5:2] missed_mask,
                                                      // [7:6] zero
    output logic                      m_axis_tuser    // [0] idle
);

    logic [ACTIVE_W-1:0] r_active;
    logic [CFG_W-1:0]    r_budgets_cfg;
    logic [CFG_W-1:0]    r_deadlines_cfg;
    logic [CFG_W-1:0]    r_periods_cfg;

    t_time_arr r_budget, n_budget;
    t_time_arr r_deadline, n_deadline;
    t_time_arr r_phase, n_phase;

    logic r_s1_valid;
    logic r_s1_restart;

    logic                 r_out_valid;
    logic [GRANT_W-1:0]   r_grant;
    logic                 r_idle;
    logic [MISS_W-1:0]    r_missed;

    t_time_arr            b0, d0, p0;
    logic [NUM_TASKS-1:0] active;
    logic [NUM_TASKS-1:0] n_missed;
    t_pick                pick;
    logic                 s1_move;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active        <= ACTIVE_RESET;
            r_budgets_cfg   <= '0;
            r_deadlines_cfg <= '0;
            r_periods_cfg   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ACTIVE_TASKS:  r_active        <= i_cfg_data[ACTIVE_W-1:0];
                REG_EXEC_BUDGETS:  r_budgets_cfg   <= i_cfg_data;
                REG_REL_DEADLINES: r_deadlines_cfg <= i_cfg_data;
                REG_TASK_PERIODS:  r_periods_cfg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;

    // Restart reloads every task ahead of the pick
    always_comb begin
        for (int t = 0; t < NUM_TASKS; t++) begin
            b0[t]     = r_s1_restart ? cfg_field(r_budgets_cfg, t)   : r_budget[t];
            d0[t]     = r_s1_restart ? cfg_field(r_deadlines_cfg, t) : r_deadline[t];
            p0[t]     = r_s1_restart ? '0                            : r_phase[t];
            active[t] = (t < int'(r_active));
        end
    end

    edf_pick u_pick (
        .i_budget   (b0),
        .i_deadline (d0),
        .i_active   (active),
        .o_pick     (pick)
    );

    always_comb begin
        t_time b1;
        t_time last;
        n_missed = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            b1 = b0[t];
            if (pick.found && (pick.idx == TASK_W'(t))) begin
                b1 = b0[t] - TIME_BITS'(1);
            end
            last          = cfg_field(r_periods_cfg, t) - TIME_BITS'(1);
            n_budget[t]   = b1;
            n_deadline[t] = d0[t];
            n_phase[t]    = p0[t];
            if (active[t]) begin
                if (p0[t] == last) begin
                    n_budget[t]   = cfg_field(r_budgets_cfg, t);
                    n_deadline[t] = cfg_field(r_deadlines_cfg, t);
                    n_phase[t]    = '0;
                end else begin
                    if (d0[t] != '0) begin
                        n_deadline[t] = d0[t] - TIME_BITS'(1);
                    end else if (b1 != '0) begin
                        n_missed[t] = 1'b1;
                    end
                    n_phase[t] = p0[t] + TIME_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TASKS; t++) begin
                r_budget[t]   <= '0;
                r_deadline[t] <= '0;
                r_phase[t]    <= '0;
            end
        end else if (s1_move) begin
            r_budget   <= n_budget;
            r_deadline <= n_deadline;
            r_phase    <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_restart <= s_axis_tdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_grant  <= pick.found ? GRANT_W'(pick.idx) : '0;
            r_idle   <= !pick.found;
            r_missed <= MISS_W'(n_missed);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_missed, r_grant};
    assign m_axis_tuser  = r_idle;

endmodule

`default_nettype wire
